### src/pde_pkg.sv
// Shared types, constants and helpers for the polynomial derivative evaluator.
package pde_pkg;

	localparam int MAX_TERMS_DEF = 16;
	localparam int COEF_W        = 32;
	localparam int ORD_W         = 6;
	localparam int VAL_W         = 64;
	localparam int MUL_W         = 32;
	localparam int PROD_W        = 2 * MUL_W;
	localparam int MAG_W         = 72;

	// Magnitude cap: anything above 2^63 is marked by 2^63 + 1
	localparam logic [VAL_W-1:0] MAG_CAP = {1'b1, {(VAL_W-2){1'b0}}, 1'b1};
	localparam logic [VAL_W-1:0] MAG_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHECK,
		S_READ,
		S_FLO,
		S_FHI,
		S_FSUM,
		S_TERM,
		S_TLO,
		S_THI,
		S_TSUM,
		S_ADD,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             clip;
	} sat_res_t;

	// Sign and magnitude to signed 64 bits with saturation
	function automatic sat_res_t from_mag(input logic neg, input logic [MAG_W-1:0] mag);
		sat_res_t res;
		res.clip = 1'b0;
		if (neg) begin
			if (mag > {{(MAG_W-VAL_W){1'b0}}, MAG_MIN}) begin
				res.clip  = 1'b1;
				res.value = MAG_MIN;
			end else begin
				res.value = VAL_W'(~mag[VAL_W-1:0] + 1'b1);
			end
		end else begin
			if (mag > {{(MAG_W-VAL_W){1'b0}}, VAL_MAX}) begin
				res.clip  = 1'b1;
				res.value = VAL_MAX;
			end else begin
				res.value = mag[VAL_W-1:0];
			end
		end
		return res;
	endfunction

	// Saturating signed 64-bit add
	function automatic sat_res_t sat_add(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
		sat_res_t          res;
		logic [VAL_W:0]    sum;
		sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		res.clip = 1'b0;
		if (sum[VAL_W] != sum[VAL_W-1]) begin
			res.clip  = 1'b1;
			res.value = sum[VAL_W] ? MAG_MIN : VAL_MAX;
		end else begin
			res.value = sum[VAL_W-1:0];
		end
		return res;
	endfunction

endpackage

### src/pde_stream_if.sv
// Valid/ready channel interfaces for coefficient words and result words.
interface pde_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] coefficient;
	logic signed [31:0] eval_point;
	logic [5:0]         derivative_order;
	logic               is_last;

	modport source (output valid, coefficient, eval_point, derivative_order, is_last,
		input ready);
	modport sink (input valid, coefficient, eval_point, derivative_order, is_last,
		output ready);
endinterface

interface pde_out_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] value;
	logic               saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink (input valid, value, saturated, output ready);
endinterface

### src/pde_coef_store.sv
// Coefficient memory: one write port, one registered read port.
module pde_coef_store #(
	parameter int DEPTH = pde_pkg::MAX_TERMS_DEF
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [pde_pkg::COEF_W-1:0]    wr_data,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [pde_pkg::COEF_W-1:0]    rd_data
);
	import pde_pkg::*;

	logic [COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

### src/pde_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
module pde_mul (
	input  logic                       clk,
	input  pde_pkg::mul_req_t          req,
	output logic [pde_pkg::PROD_W-1:0] prod
);
	import pde_pkg::*;

	always_ff @(posedge clk) begin
		prod <= PROD_W'(req.a) * PROD_W'(req.b);
	end

endmodule

### src/polynomial_derivative_eval.sv
// Top level: coefficient loading, Horner sequencer and result register.
//
// Usage: coefficient words arrive on "items", highest degree first, one per
// cycle while ready is high. The word with is_last set also carries tau
// (eval_point) and the derivative order r, and starts evaluation; ready stays
// low until the result has been placed in the output register.
// Each result word on "results" holds the Q56.8 value and a saturated flag,
// which is also set when more than MAX_TERMS coefficients were loaded.
// All products go through one shared 32x32 multiplier with a registered
// output; each 64x32 product is built from a low and a high partial product
// and their sum. For every term of degree at least r, r such products build
// its falling factorial and one more does acc * tau.
// The output register holds a result until taken; loading of the next
// polynomial carries on meanwhile, but a further evaluation holds its result
// in the sequencer, with ready low, until the register is free.
// Reset clears the term count, the overflow mark, the output valid flag and the
// sequencer; the coefficient memory is not cleared.
module polynomial_derivative_eval #(
	parameter int MAX_TERMS = pde_pkg::MAX_TERMS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	pde_in_if.sink    items,
	pde_out_if.source results
);
	import pde_pkg::*;

	localparam int AW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CW   = $clog2(MAX_TERMS + 1);
	localparam int CMPW = (CW > ORD_W) ? CW : ORD_W;

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic              ovf_q;
	logic [CW-1:0]     i_q;
	logic [ORD_W-1:0]  r_q;
	logic [ORD_W-1:0]  steps_q;
	logic [AW-1:0]     fac_q;
	logic              tneg_q;
	logic [MUL_W-1:0]  tm_q;
	logic [VAL_W-1:0]  m_q;
	logic              negc_q;
	logic [VAL_W-1:0]  t_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  am_q;
	logic              np_q;
	logic [PROD_W-1:0] plo_q;
	logic [VAL_W-1:0]  mt_q;
	logic              clip_q;
	logic              ov_q;
	logic [VAL_W-1:0]  value_q;
	logic              sat_q;

	logic              accept;
	logic              wr_en;
	logic [COEF_W-1:0] rd_data;
	mul_req_t          mreq;
	logic [PROD_W-1:0] prod;

	logic [CW-1:0]     n_full;
	logic              term_ok;
	logic              out_free;
	logic [COEF_W-1:0] cmag;
	logic [95:0]       fsum;
	logic [MAG_W-1:0]  tsum;
	logic              tcap;
	sat_res_t          term_fm;
	sat_res_t          tau_fm;
	sat_res_t          add_res;

	assign accept   = items.valid && items.ready;
	assign wr_en    = accept && (count_q < CW'(MAX_TERMS));
	assign out_free = !ov_q || results.ready;

	// degree of the term at i; only meaningful while i < count
	assign n_full  = count_q - CW'(1) - i_q;
	assign term_ok = (i_q < count_q) && (CMPW'(n_full) >= CMPW'(r_q));

	assign cmag = rd_data[COEF_W-1] ? (~rd_data + 1'b1) : rd_data;
	assign fsum = {prod, 32'b0} + {32'b0, plo_q};
	assign tcap = prod[PROD_W-1:55] != '0;
	assign tsum = {prod, 8'b0} + {{(MAG_W-40){1'b0}}, plo_q[PROD_W-1:24]};

	assign term_fm = from_mag(negc_q, {{(MAG_W-VAL_W){1'b0}}, m_q});
	assign tau_fm  = from_mag(np_q, tcap ? {{(MAG_W-VAL_W){1'b0}}, MAG_CAP} : tsum);
	assign add_res = sat_add(mt_q, t_q);

	pde_coef_store #(
		.DEPTH(MAX_TERMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(items.coefficient),
		.rd_addr(i_q[AW-1:0]),
		.rd_data(rd_data)
	);

	pde_mul u_mul (
		.clk (clk),
		.req (mreq),
		.prod(prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		items.ready = 1'b0;
		mreq        = '0;
		unique case (state_q)
			S_LOAD: begin
				items.ready = 1'b1;
				if (items.valid && items.is_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = term_ok ? S_READ : S_OUT;
			S_READ:  state_d = (r_q == '0) ? S_TERM : S_FLO;
			S_FLO: begin
				mreq.a  = m_q[31:0];
				mreq.b  = MUL_W'(fac_q);
				state_d = S_FHI;
			end
			S_FHI: begin
				mreq.a  = m_q[63:32];
				mreq.b  = MUL_W'(fac_q);
				state_d = S_FSUM;
			end
			S_FSUM:  state_d = (steps_q == ORD_W'(1)) ? S_TERM : S_FLO;
			S_TERM:  state_d = S_TLO;
			S_TLO: begin
				mreq.a  = am_q[31:0];
				mreq.b  = tm_q;
				state_d = S_THI;
			end
			S_THI: begin
				mreq.a  = am_q[63:32];
				mreq.b  = tm_q;
				state_d = S_TSUM;
			end
			S_TSUM:  state_d = S_ADD;
			S_ADD:   state_d = S_CHECK;
			S_OUT: begin
				if (out_free) begin
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (accept) begin
				if (wr_en) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == S_OUT && out_free) begin
				ov_q    <= 1'b1;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (ov_q && results.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (state_q == S_FHI || state_q == S_THI) begin
			plo_q <= prod;
		end
		case (state_q)
			S_LOAD: begin
				if (accept && items.is_last) begin
					tneg_q <= items.eval_point[31];
					tm_q   <= items.eval_point[31] ? (~items.eval_point + 1'b1)
						: items.eval_point;
					r_q    <= items.derivative_order;
					i_q    <= '0;
					acc_q  <= '0;
					clip_q <= 1'b0;
				end
			end
			S_READ: begin
				m_q     <= {24'b0, cmag, 8'b0};
				negc_q  <= rd_data[COEF_W-1];
				fac_q   <= n_full[AW-1:0];
				steps_q <= r_q;
			end
			S_FSUM: begin
				m_q     <= (fsum > {32'b0, MAG_CAP}) ? MAG_CAP : fsum[VAL_W-1:0];
				fac_q   <= fac_q - AW'(1);
				steps_q <= steps_q - ORD_W'(1);
			end
			S_TERM: begin
				t_q    <= term_fm.value;
				clip_q <= clip_q | term_fm.clip;
				am_q   <= acc_q[VAL_W-1] ? (~acc_q + 1'b1) : acc_q;
				np_q   <= acc_q[VAL_W-1] ^ tneg_q;
			end
			S_TSUM: begin
				mt_q   <= tau_fm.value;
				clip_q <= clip_q | tau_fm.clip | tcap;
			end
			S_ADD: begin
				acc_q  <= add_res.value;
				clip_q <= clip_q | add_res.clip;
				i_q    <= i_q + CW'(1);
			end
			S_OUT: begin
				if (out_free) begin
					value_q <= acc_q;
					sat_q   <= clip_q | ovf_q;
				end
			end
			default: ;
		endcase
	end

	assign results.valid     = ov_q;
	assign results.value     = value_q;
	assign results.saturated = sat_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TERMS))
		else $error("term count beyond store depth");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && items.is_last) |=> !items.ready)
		else $error("ready high after last word");

	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (results.valid && count_q == '0 && !ovf_q))
		else $error("result not posted or load state not cleared");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (i_q <= count_q))
		else $error("term index beyond count");

	a_fac_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLO) |-> (steps_q != '0))
		else $error("factorial step with no steps left");

endmodule
